// File: hw/rtl/cgc_pkg.sv
// Shared types and constants for the contact gesture classifier.
`timescale 1ns / 1ps
package cgc_pkg;

  localparam int unsigned LEVEL_BITS_DEF = 12;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned CFG_TIME_W     = 24;
  localparam int unsigned GOAL_W         = 8;
  localparam int unsigned CFG_DATA_W     = 24;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CODE_W         = 3;

  localparam logic [TIME_W-1:0] ATTACK_GRACE_US = 32'd8000;

  localparam logic [CFG_TIME_W-1:0] RETRIGGER_GUARD_RST = 24'd60000;
  localparam logic [CFG_TIME_W-1:0] SCRAPE_WINDOW_RST   = 24'd40000;
  localparam logic [CFG_TIME_W-1:0] HARMONIC_HOLD_RST   = 24'd70000;
  localparam logic [CFG_TIME_W-1:0] MUTE_WINDOW_RST     = 24'd50000;
  localparam logic [CFG_TIME_W-1:0] WOBBLE_PERIOD_RST   = 24'd30000;
  localparam logic [GOAL_W-1:0]     FLIP_GOAL_RST       = 8'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTACT_ON    = 3'd0,
    REG_CONTACT_OFF   = 3'd1,
    REG_RETRIG_GUARD  = 3'd2,
    REG_SCRAPE_WINDOW = 3'd3,
    REG_HARMONIC_HOLD = 3'd4,
    REG_MUTE_WINDOW   = 3'd5,
    REG_WOBBLE_PERIOD = 3'd6,
    REG_FLIP_GOAL     = 3'd7
  } cfg_reg_e;

  typedef enum logic [CODE_W-1:0] {
    G_IDLE     = 3'd0,
    G_PLUCK    = 3'd1,
    G_BOW      = 3'd2,
    G_SCRAPE   = 3'd3,
    G_HARMONIC = 3'd4,
    G_MUTED    = 3'd5,
    G_TREMOLO  = 3'd6,
    G_VIBRATO  = 3'd7
  } gesture_e;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_ATTACK   = 2'd1,
    PH_SUSTAIN  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] retrigger_guard_us;
    logic [CFG_TIME_W-1:0] scrape_gap_us;
    logic [CFG_TIME_W-1:0] harm_dwell_us;
    logic [CFG_TIME_W-1:0] mute_gap_us;
    logic [CFG_TIME_W-1:0] wobble_period_us;
    logic [GOAL_W-1:0]     flip_goal;
  } cfg_time_t;

endpackage

// File: hw/rtl/cgc_cfg.sv
// Configuration register file for the contact gesture classifier.
`timescale 1ns / 1ps
module cgc_cfg #(
  parameter int unsigned LEVEL_BITS = cgc_pkg::LEVEL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cgc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cgc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [LEVEL_BITS-1:0]          contact_on_level_o,
  output logic [LEVEL_BITS-1:0]          contact_off_level_o,
  output cgc_pkg::cfg_time_t             cfg_time_o
);
  import cgc_pkg::*;

  localparam int FullScale = (1 << LEVEL_BITS) - 1;
  localparam logic [LEVEL_BITS-1:0] OnRst  = LEVEL_BITS'((55 * FullScale) / 100);
  localparam logic [LEVEL_BITS-1:0] OffRst = LEVEL_BITS'((40 * FullScale) / 100);

  logic [LEVEL_BITS-1:0] on_q, on_d, off_q, off_d;
  cfg_time_t             time_q, time_d;

  always_comb begin
    on_d   = on_q;
    off_d  = off_q;
    time_d = time_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CONTACT_ON:    on_d = cfg_wdata_i[LEVEL_BITS-1:0];
        REG_CONTACT_OFF:   off_d = cfg_wdata_i[LEVEL_BITS-1:0];
        REG_RETRIG_GUARD:  time_d.retrigger_guard_us = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_SCRAPE_WINDOW: time_d.scrape_gap_us = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_HARMONIC_HOLD: time_d.harm_dwell_us = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_MUTE_WINDOW:   time_d.mute_gap_us = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_WOBBLE_PERIOD: time_d.wobble_period_us = cfg_wdata_i[CFG_TIME_W-1:0];
        REG_FLIP_GOAL:     time_d.flip_goal = cfg_wdata_i[GOAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q                      <= OnRst;
      off_q                     <= OffRst;
      time_q.retrigger_guard_us <= RETRIGGER_GUARD_RST;
      time_q.scrape_gap_us      <= SCRAPE_WINDOW_RST;
      time_q.harm_dwell_us      <= HARMONIC_HOLD_RST;
      time_q.mute_gap_us        <= MUTE_WINDOW_RST;
      time_q.wobble_period_us   <= WOBBLE_PERIOD_RST;
      time_q.flip_goal          <= FLIP_GOAL_RST;
    end else begin
      on_q   <= on_d;
      off_q  <= off_d;
      time_q <= time_d;
    end
  end

  assign contact_on_level_o  = on_q;
  assign contact_off_level_o = off_q;
  assign cfg_time_o          = time_q;

endmodule

// File: hw/rtl/cgc_core.sv
// Contact tracking state and per-sample gesture decision.
`timescale 1ns / 1ps
module cgc_core #(
  parameter int unsigned LEVEL_BITS = cgc_pkg::LEVEL_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [LEVEL_BITS-1:0]      level_i,
  input  logic [cgc_pkg::TIME_W-1:0] time_i,
  input  logic [LEVEL_BITS-1:0]      contact_on_level_i,
  input  logic [LEVEL_BITS-1:0]      contact_off_level_i,
  input  cgc_pkg::cfg_time_t         cfg_time_i,
  output cgc_pkg::gesture_e          gesture_o
);
  import cgc_pkg::*;

  localparam int FullScale = (1 << LEVEL_BITS) - 1;
  localparam logic [LEVEL_BITS-1:0] HarmPeakMin  = LEVEL_BITS'((35 * FullScale + 99) / 100);
  localparam logic [LEVEL_BITS-1:0] HarmPeakMax  = LEVEL_BITS'((65 * FullScale) / 100);
  localparam logic [LEVEL_BITS-1:0] HarmStillMax = LEVEL_BITS'((5 * FullScale) / 100);
  localparam logic [LEVEL_BITS-1:0] MutePeakMax  = LEVEL_BITS'((25 * FullScale) / 100);
  localparam logic [LEVEL_BITS-1:0] MuteRelMax   = LEVEL_BITS'((15 * FullScale) / 100);
  localparam logic [LEVEL_BITS-1:0] FlipSwingMin = LEVEL_BITS'((6 * FullScale + 99) / 100);
  localparam logic [LEVEL_BITS-1:0] VibDepthMin  = LEVEL_BITS'((15 * FullScale + 99) / 100);
  localparam logic [GOAL_W-1:0]     FlipMax      = '1;

  logic                  contact_q, contact_d;
  logic [TIME_W-1:0]     onset_time_q, onset_time_d;
  logic [TIME_W-1:0]     start_q, start_d;
  logic [LEVEL_BITS-1:0] peak_q, peak_d;
  logic [LEVEL_BITS-1:0] prev_q, prev_d;
  logic [LEVEL_BITS-1:0] low_q, low_d;
  logic [LEVEL_BITS-1:0] high_q, high_d;
  logic [GOAL_W-1:0]     flips_q, flips_d;
  logic [TIME_W-1:0]     flip_time_q, flip_time_d;
  logic                  rising_q, rising_d;
  logic                  harm_done_q, harm_done_d;
  logic                  mod_done_q, mod_done_d;
  logic                  mute_q, mute_d;
  phase_e                phase_q, phase_d;

  logic                  touch_on, onset, released, rising;
  logic [LEVEL_BITS-1:0] swing, depth;
  logic [TIME_W-1:0]     gap, held;
  logic                  band;
  gesture_e              gesture;

  always_comb begin
    touch_on     = contact_q | (level_i >= contact_on_level_i);
    contact_d    = touch_on & ~(level_i <= contact_off_level_i);
    onset        = contact_d & ~contact_q;
    released     = contact_q & ~contact_d;

    onset_time_d = onset_time_q;
    start_d      = onset ? time_i : start_q;
    peak_d       = onset ? level_i : peak_q;
    low_d        = onset ? level_i : low_q;
    high_d       = onset ? level_i : high_q;
    flips_d      = onset ? '0 : flips_q;
    flip_time_d  = onset ? time_i : flip_time_q;
    rising_d     = onset ? 1'b1 : rising_q;
    harm_done_d  = onset ? 1'b0 : harm_done_q;
    mod_done_d   = onset ? 1'b0 : mod_done_q;
    mute_d       = onset ? 1'b0 : mute_q;
    phase_d      = onset ? PH_ATTACK : phase_q;

    held = time_i - start_d;
    if (contact_d) begin
      if (level_i > peak_d) peak_d = level_i;
      if (level_i < low_d) low_d = level_i;
      if (level_i > high_d) high_d = level_i;
      if (phase_d == PH_ATTACK && held > ATTACK_GRACE_US) phase_d = PH_SUSTAIN;
    end

    rising = level_i >= prev_q;
    swing  = rising ? level_i - prev_q : prev_q - level_i;
    if (swing >= FlipSwingMin && phase_d == PH_SUSTAIN && rising != rising_d) begin
      if ((time_i - flip_time_d) <= TIME_W'(cfg_time_i.wobble_period_us)) begin
        if (flips_d != FlipMax) flips_d = flips_d + 1'b1;
      end else begin
        flips_d = GOAL_W'(1);
      end
      flip_time_d = time_i;
      rising_d    = rising;
    end
    prev_d = level_i;

    gap     = time_i - onset_time_q;
    band    = (peak_d >= HarmPeakMin) && (peak_d <= HarmPeakMax);
    depth   = (high_d >= low_d) ? high_d - low_d : '0;
    gesture = G_IDLE;
    if (onset) begin
      if (gap >= TIME_W'(cfg_time_i.retrigger_guard_us)) begin
        gesture      = (gap < TIME_W'(cfg_time_i.scrape_gap_us)) ? G_SCRAPE : G_PLUCK;
        onset_time_d = time_i;
      end
    end else if (contact_d) begin
      if (!harm_done_d && band && depth <= HarmStillMax &&
          held > TIME_W'(cfg_time_i.harm_dwell_us)) begin
        harm_done_d = 1'b1;
        gesture     = G_HARMONIC;
      end else if (!mod_done_d && flips_d >= cfg_time_i.flip_goal) begin
        mod_done_d = 1'b1;
        gesture    = (depth >= VibDepthMin) ? G_VIBRATO : G_TREMOLO;
      end else begin
        gesture = G_BOW;
      end
      if (peak_d <= MutePeakMax && level_i <= MuteRelMax) mute_d = 1'b1;
    end else if (released) begin
      phase_d = PH_RELEASED;
      if (held <= TIME_W'(cfg_time_i.mute_gap_us) || mute_d) gesture = G_MUTED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_q    <= 1'b0;
      onset_time_q <= '0;
      start_q      <= '0;
      peak_q       <= '0;
      prev_q       <= '0;
      low_q        <= '1;
      high_q       <= '0;
      flips_q      <= '0;
      flip_time_q  <= '0;
      rising_q     <= 1'b1;
      harm_done_q  <= 1'b0;
      mod_done_q   <= 1'b0;
      mute_q       <= 1'b0;
      phase_q      <= PH_RELEASED;
    end else if (step_i) begin
      contact_q    <= contact_d;
      onset_time_q <= onset_time_d;
      start_q      <= start_d;
      peak_q       <= peak_d;
      prev_q       <= prev_d;
      low_q        <= low_d;
      high_q       <= high_d;
      flips_q      <= flips_d;
      flip_time_q  <= flip_time_d;
      rising_q     <= rising_d;
      harm_done_q  <= harm_done_d;
      mod_done_q   <= mod_done_d;
      mute_q       <= mute_d;
      phase_q      <= phase_d;
    end
  end

  assign gesture_o = gesture;

endmodule

// File: hw/rtl/contact_gesture_classifier.sv
// Contact gesture classifier: one gesture code per sensor sample.
// Path from sample transaction to gesture valid: input register, then result register.
// Throughput: one sample per cycle without stalls; the whole step sits between the two registers.
// Output stalls back-pressure the input stage only once both registers are full.
// Reset clears contact tracking and both pipeline stages and loads the default thresholds.
`timescale 1ns / 1ps
module contact_gesture_classifier #(
  parameter int unsigned LEVEL_BITS = cgc_pkg::LEVEL_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           sample_valid_i,
  output logic                           sample_ready_o,
  input  logic [LEVEL_BITS-1:0]          sample_level_i,
  input  logic [cgc_pkg::TIME_W-1:0]     sample_time_us_i,
  output logic                           gesture_valid_o,
  input  logic                           gesture_ready_i,
  output logic [cgc_pkg::CODE_W-1:0]     gesture_code_o,
  input  logic                           cfg_we_i,
  input  logic [cgc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cgc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import cgc_pkg::*;

  logic                  in_valid_q, in_valid_d;
  logic [LEVEL_BITS-1:0] level_q;
  logic [TIME_W-1:0]     time_q;
  logic                  out_valid_q, out_valid_d;
  gesture_e              code_q;
  logic                  advance, take;
  logic [LEVEL_BITS-1:0] on_level, off_level;
  cfg_time_t             cfg_time;
  gesture_e              gesture;

  cgc_cfg #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_cfg (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .contact_on_level_o (on_level),
    .contact_off_level_o(off_level),
    .cfg_time_o         (cfg_time)
  );

  cgc_core #(
    .LEVEL_BITS(LEVEL_BITS)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (advance),
    .level_i            (level_q),
    .time_i             (time_q),
    .contact_on_level_i (on_level),
    .contact_off_level_i(off_level),
    .cfg_time_i         (cfg_time),
    .gesture_o          (gesture)
  );

  assign advance        = in_valid_q & (~out_valid_q | gesture_ready_i);
  assign sample_ready_o = ~in_valid_q | advance;
  assign take           = sample_valid_i & sample_ready_o;

  always_comb begin
    in_valid_d  = take | (in_valid_q & ~advance);
    out_valid_d = advance | (out_valid_q & ~gesture_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      level_q <= sample_level_i;
      time_q  <= sample_time_us_i;
    end
    if (advance) begin
      code_q <= gesture;
    end
  end

  assign gesture_valid_o = out_valid_q;
  assign gesture_code_o  = code_q;

endmodule
